[rtl/sfp_pkg.sv]
// sfp_pkg: shared types, constants and the saturation helper for the
// spring-follow point unit. No dependencies.
`default_nettype none

package sfp_pkg;

	localparam int IDX_W   = 10;
	localparam int COORD_W = 32;
	localparam int K_W     = 16;
	localparam int DT_W    = 16;
	localparam int COEF_W  = 24;
	localparam int N_AXES  = 3;
	localparam int SAT_W   = 48;

	localparam logic OP_INIT = 1'b0;
	localparam logic OP_STEP = 1'b1;

	localparam logic [K_W-1:0] DAMPING_RESET = 16'd256;

	typedef logic signed [COORD_W-1:0] coord_t;

	typedef struct packed {
		logic              opcode;
		logic [IDX_W-1:0]  point_index;
		coord_t            target_x;
		coord_t            target_y;
		coord_t            target_z;
		logic [K_W-1:0]    stiffness;
		logic [DT_W-1:0]   time_step;
	} item_t;

	typedef struct packed {
		logic [IDX_W-1:0]  out_index;
		coord_t            pos_x;
		coord_t            pos_y;
		coord_t            pos_z;
	} result_t;

	// position and velocity of one axis, as held in memory
	typedef struct packed {
		coord_t pos;
		coord_t vel;
	} pv_t;

	typedef struct packed {
		coord_t p_new;
		coord_t v_new;
		coord_t tgt;
	} lane_res_t;

	typedef struct packed {
		logic              opcode;
		logic [IDX_W-1:0]  point_index;
		logic              in_range;
		logic [K_W-1:0]    stiffness;
	} ctl_t;

	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
		logic s5;
	} stage_en_t;

	typedef struct packed {
		logic                   pv_we;
		logic                   k_we;
		pv_t [N_AXES-1:0]       pv;
	} wr_t;

	function automatic coord_t sat32(input logic signed [SAT_W-1:0] x);
		coord_t r;
		if ((x[SAT_W-1:COORD_W-1] == '0) || (x[SAT_W-1:COORD_W-1] == '1)) begin
			r = x[COORD_W-1:0];
		end else if (x[SAT_W-1]) begin
			r = 32'sh8000_0000;
		end else begin
			r = 32'sh7FFF_FFFF;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

[rtl/spring_follow_points_3d_unit.sv]
// spring_follow_points_3d_unit: top level of the spring-follow point table.
// Depends on sfp_pkg, sfp_ram, sfp_lane and sfp_merge.
//
// channel  direction  handshake                   payload
// item     in         item_valid / item_stall     sfp_pkg::item_t
// result   out        result_valid / result_stall sfp_pkg::result_t
// cfg      in         cfg_valid / cfg_ready       cfg_data: damping, Q8.8
//
// One item per clock while no item for the same point is still in flight and result_stall does not hold the pipeline.
// After its item is accepted, a result passes through the five stages and
// the output register before it is valid.
// An item for a point still in flight waits until the earlier item has been
// written back from stage five; while result_stall holds stage five, that
// write-back is delayed.
// Reset empties the pipeline and sets damping to 1.0; point memories are
// not cleared.
// result_stall holds the output register; earlier stages keep filling
// until every stage is occupied.
`default_nettype none

module spring_follow_points_3d_unit #(
	parameter int MAX_POINTS = 1024
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       item_valid,
	output logic                       item_stall,
	input  sfp_pkg::item_t             item,
	output logic                       result_valid,
	input  logic                       result_stall,
	output sfp_pkg::result_t           result,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [sfp_pkg::K_W-1:0]    cfg_data
);

	localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int XW = (AW > sfp_pkg::IDX_W) ? AW : sfp_pkg::IDX_W;

	sfp_pkg::stage_en_t                      en;
	logic                                    in_accept;
	logic                                    in_range;
	logic                                    hazard;
	logic                                    s5_ready;
	logic                                    v_s1, v_s2, v_s3, v_s4, v_s5;
	sfp_pkg::ctl_t                           ctl_s1, ctl_s2, ctl_s3, ctl_s4, ctl_s5;
	logic [sfp_pkg::DT_W-1:0]                dt_s1, dt_s2, dt_s3, dt_s4;
	logic [sfp_pkg::COEF_W-1:0]              kdt_s2, ldt_s2, ldt_s3, ldt_s4;
	logic [31:0]                             kprod, lprod;
	logic [sfp_pkg::K_W-1:0]                 damping_q;
	logic [sfp_pkg::K_W-1:0]                 k_rd;
	logic [XW-1:0]                           ridx_ext, widx_ext;
	logic [AW-1:0]                           raddr, waddr;
	sfp_pkg::coord_t [sfp_pkg::N_AXES-1:0]   tgt_in;
	sfp_pkg::pv_t [sfp_pkg::N_AXES-1:0]      pv_rd;
	sfp_pkg::lane_res_t [sfp_pkg::N_AXES-1:0] lane_res;
	sfp_pkg::wr_t                            wr;

	// stage enables: a stage loads when it is empty or its contents move on
	assign en.s5 = !v_s5 || s5_ready;
	assign en.s4 = !v_s4 || en.s5;
	assign en.s3 = !v_s3 || en.s4;
	assign en.s2 = !v_s2 || en.s3;
	assign en.s1 = !v_s1 || en.s2;

	// same point already in flight: hold off until written back
	assign hazard = (v_s1 && (ctl_s1.point_index == item.point_index))
		|| (v_s2 && (ctl_s2.point_index == item.point_index))
		|| (v_s3 && (ctl_s3.point_index == item.point_index))
		|| (v_s4 && (ctl_s4.point_index == item.point_index))
		|| (v_s5 && (ctl_s5.point_index == item.point_index));

	assign item_stall = !en.s1 || hazard;
	assign in_accept  = item_valid && !item_stall;
	assign in_range   = (32'(item.point_index) < 32'(MAX_POINTS));
	assign cfg_ready  = 1'b1;

	assign ridx_ext = XW'(item.point_index);
	assign raddr    = ridx_ext[AW-1:0];
	assign widx_ext = XW'(ctl_s5.point_index);
	assign waddr    = widx_ext[AW-1:0];

	assign tgt_in = {item.target_z, item.target_y, item.target_x};

	// s1: k*dt and damping*dt, rounded to Q8.16
	assign kprod = ({16'd0, k_rd} * {16'd0, dt_s1}) + 32'd128;
	assign lprod = ({16'd0, damping_q} * {16'd0, dt_s1}) + 32'd128;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			v_s4      <= 1'b0;
			v_s5      <= 1'b0;
			damping_q <= sfp_pkg::DAMPING_RESET;
		end else begin
			if (en.s1) begin
				v_s1 <= in_accept;
			end
			if (en.s2) begin
				v_s2 <= v_s1;
			end
			if (en.s3) begin
				v_s3 <= v_s2;
			end
			if (en.s4) begin
				v_s4 <= v_s3;
			end
			if (en.s5) begin
				v_s5 <= v_s4;
			end
			if (cfg_valid && cfg_ready) begin
				damping_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en.s1) begin
			ctl_s1 <= '{opcode: item.opcode, point_index: item.point_index,
				in_range: in_range, stiffness: item.stiffness};
			dt_s1  <= item.time_step;
		end
		if (en.s2) begin
			ctl_s2 <= ctl_s1;
			dt_s2  <= dt_s1;
			kdt_s2 <= kprod[31:8];
			ldt_s2 <= lprod[31:8];
		end
		if (en.s3) begin
			ctl_s3 <= ctl_s2;
			dt_s3  <= dt_s2;
			ldt_s3 <= ldt_s2;
		end
		if (en.s4) begin
			ctl_s4 <= ctl_s3;
			dt_s4  <= dt_s3;
			ldt_s4 <= ldt_s3;
		end
		if (en.s5) begin
			ctl_s5 <= ctl_s4;
		end
	end

	sfp_ram #(
		.W     (sfp_pkg::K_W),
		.DEPTH (MAX_POINTS)
	) u_k_ram (
		.clk   (clk),
		.we    (wr.k_we),
		.waddr (waddr),
		.wdata (ctl_s5.stiffness),
		.re    (in_accept),
		.raddr (raddr),
		.rdata (k_rd)
	);

	for (genvar a = 0; a < sfp_pkg::N_AXES; a++) begin : g_axis
		sfp_ram #(
			.W     ($bits(sfp_pkg::pv_t)),
			.DEPTH (MAX_POINTS)
		) u_pv_ram (
			.clk   (clk),
			.we    (wr.pv_we),
			.waddr (waddr),
			.wdata (wr.pv[a]),
			.re    (in_accept),
			.raddr (raddr),
			.rdata (pv_rd[a])
		);

		sfp_lane u_lane (
			.clk   (clk),
			.en    (en),
			.tgt   (tgt_in[a]),
			.pv_rd (pv_rd[a]),
			.kdt   (kdt_s2),
			.dt    (dt_s4),
			.ldt   (ldt_s4),
			.res   (lane_res[a])
		);
	end

	sfp_merge u_merge (
		.clk          (clk),
		.arst_n       (arst_n),
		.valid        (v_s5),
		.ctl          (ctl_s5),
		.res          (lane_res),
		.result_stall (result_stall),
		.ready        (s5_ready),
		.wr           (wr),
		.result_valid (result_valid),
		.result       (result)
	);

	a_no_rw_collision: assert property (@(posedge clk) disable iff (!arst_n)
		(wr.pv_we && in_accept && in_range) |-> (waddr != raddr))
		else $error("read of a point issued while it is written back");

	a_s5_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s5 && !s5_ready) |=> (v_s5 && $stable(ctl_s5.point_index)))
		else $error("stage five lost its item while blocked");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(v_s5))
		else $error("result appeared without an item in stage five");

endmodule

`default_nettype wire

[rtl/sfp_ram.sv]
// sfp_ram: generic simple dual-port RAM, one write and one registered read.
// No dependencies.
`default_nettype none

module sfp_ram #(
	parameter int W     = 32,
	parameter int DEPTH = 1024,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [W-1:0]  wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [W-1:0]  rdata
);

	logic [W-1:0] mem_q [DEPTH];
	logic [W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

[rtl/sfp_lane.sv]
// sfp_lane: one axis of the damped spring update, stages s1 to s5.
// Depends on sfp_pkg.
`default_nettype none

module sfp_lane (
	input  logic                       clk,
	input  sfp_pkg::stage_en_t         en,
	input  sfp_pkg::coord_t            tgt,
	input  sfp_pkg::pv_t               pv_rd,
	input  logic [sfp_pkg::COEF_W-1:0] kdt,
	input  logic [sfp_pkg::DT_W-1:0]   dt,
	input  logic [sfp_pkg::COEF_W-1:0] ldt,
	output sfp_pkg::lane_res_t         res
);

	sfp_pkg::coord_t tgt_s1, tgt_s2, tgt_s3, tgt_s4, tgt_s5;
	sfp_pkg::coord_t p_s2, p_s3, p_s4, p_s5;
	sfp_pkg::coord_t v_s2, v_s3, v1_s4;
	logic signed [32:0] diff, diff_s2;
	logic signed [57:0] prod, prod_s3;
	logic signed [41:0] dv;
	logic signed [42:0] vsub;
	sfp_pkg::coord_t    v1;
	logic signed [48:0] pm, pm_s5;
	logic signed [56:0] vm, vm_s5;
	logic signed [33:0] psum;

	// s1: offset from target
	assign diff = 33'(pv_rd.pos) - 33'(tgt_s1);

	// s2: k*dt*(p - t), rounding half folded in
	assign prod = ($signed({1'b0, kdt}) * diff_s2) + 58'sd32768;

	// s3: new velocity before damping
	assign dv   = 42'(prod_s3 >>> 16);
	assign vsub = 43'(v_s3) - 43'(dv);
	assign v1   = sfp_pkg::sat32(48'(vsub));

	// s4: v1*dt and v1*ldt
	assign pm = (v1_s4 * $signed({1'b0, dt})) + 49'sd32768;
	assign vm = (v1_s4 * $signed({1'b0, ldt})) + 57'sd32768;

	// s5: position update and damped velocity
	assign psum = 34'(p_s5) + 34'(pm_s5 >>> 16);

	always_ff @(posedge clk) begin
		if (en.s1) begin
			tgt_s1 <= tgt;
		end
		if (en.s2) begin
			diff_s2 <= diff;
			p_s2    <= pv_rd.pos;
			v_s2    <= pv_rd.vel;
			tgt_s2  <= tgt_s1;
		end
		if (en.s3) begin
			prod_s3 <= prod;
			p_s3    <= p_s2;
			v_s3    <= v_s2;
			tgt_s3  <= tgt_s2;
		end
		if (en.s4) begin
			v1_s4  <= v1;
			p_s4   <= p_s3;
			tgt_s4 <= tgt_s3;
		end
		if (en.s5) begin
			pm_s5  <= pm;
			vm_s5  <= vm;
			p_s5   <= p_s4;
			tgt_s5 <= tgt_s4;
		end
	end

	assign res.p_new = sfp_pkg::sat32(48'(psum));
	assign res.v_new = sfp_pkg::sat32(48'(vm_s5 >>> 16));
	assign res.tgt   = tgt_s5;

endmodule

`default_nettype wire

[rtl/sfp_merge.sv]
// sfp_merge: combines the three lanes into write-back data and the result
// item, and holds the output register. Depends on sfp_pkg.
`default_nettype none

module sfp_merge (
	input  logic                                          clk,
	input  logic                                          arst_n,
	input  logic                                          valid,
	input  sfp_pkg::ctl_t                                 ctl,
	input  sfp_pkg::lane_res_t [sfp_pkg::N_AXES-1:0]      res,
	input  logic                                          result_stall,
	output logic                                          ready,
	output sfp_pkg::wr_t                                  wr,
	output logic                                          result_valid,
	output sfp_pkg::result_t                              result
);

	logic                               take;
	logic                               is_init;
	sfp_pkg::pv_t [sfp_pkg::N_AXES-1:0] pv_new;
	sfp_pkg::result_t                   res_d;
	sfp_pkg::result_t                   result_q;
	logic                               valid_q;

	assign ready   = !valid_q || !result_stall;
	assign take    = valid && ready;
	assign is_init = (ctl.opcode == sfp_pkg::OP_INIT);

	always_comb begin
		for (int a = 0; a < sfp_pkg::N_AXES; a++) begin
			if (is_init) begin
				pv_new[a] = '{pos: res[a].tgt, vel: '0};
			end else begin
				pv_new[a] = '{pos: res[a].p_new, vel: res[a].v_new};
			end
		end
	end

	assign wr.pv_we = take && ctl.in_range;
	assign wr.k_we  = take && ctl.in_range && is_init;
	assign wr.pv    = pv_new;

	always_comb begin
		res_d.out_index = ctl.point_index;
		res_d.pos_x     = ctl.in_range ? pv_new[0].pos : '0;
		res_d.pos_y     = ctl.in_range ? pv_new[1].pos : '0;
		res_d.pos_z     = ctl.in_range ? pv_new[2].pos : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ready) begin
			valid_q <= valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			result_q <= res_d;
		end
	end

	assign result_valid = valid_q;
	assign result       = result_q;

endmodule

`default_nettype wire
